// ===== hdl/wpi_pkg.sv =====
// ----------------------------------------------------------------------------
// wpi_pkg: shared types and constants of the waypoint path interpolator
// Request codes, coordinate widths and the control word handed to the
// shared divide / square root unit.
// ----------------------------------------------------------------------------
package wpi_pkg;

  localparam int CoordW = 24;
  localparam int CountW = 16;
  localparam int VelW   = 16;
  localparam int DefQueueDepth = 16;

  // request codes
  localparam logic [1:0] FUNC_MOVE  = 2'd0;
  localparam logic [1:0] FUNC_JUMP  = 2'd1;
  localparam logic [1:0] FUNC_TICK  = 2'd2;
  localparam logic [1:0] FUNC_RESET = 2'd3;

  // shared unit operations
  localparam logic OP_SQRT = 1'b0;
  localparam logic OP_DIV  = 1'b1;

  // command to the shared unit
  typedef struct packed {
    logic        start;
    logic        op;
    logic [49:0] num;   // radicand (50 bits) or magnitude dividend
    logic [31:0] den;   // divisor
  } wpi_cmd_t;

endpackage

// ===== hdl/wpi_divsqrt.sv =====
// ----------------------------------------------------------------------------
// wpi_divsqrt: shared iterative divide and square root
// Restoring unsigned divide, one quotient bit per cycle, or restoring square
// root, one root bit per cycle, on the same subtract / compare datapath.
// ----------------------------------------------------------------------------
module wpi_divsqrt
  import wpi_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  wpi_cmd_t    cmd,
  output logic        done,
  output logic [49:0] result
);

  logic        busy;
  logic        op;
  logic [5:0]  cnt;
  logic [49:0] num;
  logic [51:0] rem;
  logic [49:0] quo;
  logic [31:0] den;

  logic [51:0] rem_sh;
  logic [51:0] trial;
  logic        take;

  // one step: shift in one (div) or two (sqrt) bits and test-subtract
  always_comb begin
    if (op == OP_DIV) begin
      rem_sh = {rem[50:0], num[49]};
      trial  = {20'd0, den};
    end else begin
      rem_sh = {rem[49:0], num[49:48]};
      trial  = {quo[49:0], 2'b01};
    end
    take = (rem_sh >= trial);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cmd.start) begin
        busy <= 1'b1;
        op   <= cmd.op;
        num  <= cmd.num;
        den  <= cmd.den;
        rem  <= '0;
        quo  <= '0;
        cnt  <= (cmd.op == OP_DIV) ? 6'd50 : 6'd25;
      end else if (busy) begin
        rem <= take ? rem_sh - trial : rem_sh;
        quo <= {quo[48:0], take};
        num <= (op == OP_DIV) ? {num[48:0], 1'b0} : {num[47:0], 2'b00};
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign result = quo;

endmodule

// ===== hdl/waypoint_path_interpolator.sv =====
// ----------------------------------------------------------------------------
// waypoint_path_interpolator: queued 2D linear waypoint stepping
// Top level: request decode, segment queue and step sequencer.
// ----------------------------------------------------------------------------
// One request word in, one result word out. A move with nonzero velocity runs a
// square root then a divide; an interpolating render tick, which may also load
// a segment, runs two divides, one per axis; a final step lands on the end point
// without a divide. All long work runs on the one shared divide / square root
// unit, one bit per cycle. The block is not ready while a request is in
// progress or its result is held, so the next word is taken in the cycle after
// the result is accepted.
// ----------------------------------------------------------------------------
module waypoint_path_interpolator
  import wpi_pkg::*;
#(
  parameter int QUEUE_DEPTH = DefQueueDepth
)(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // target_x, target_y, velocity
  input  logic [1:0]  s_tuser,   // func
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // pos_x, pos_y
  output logic [1:0]  m_tuser    // moved, dropped
);

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int FW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [AW-1:0] LastIdx = AW'(QUEUE_DEPTH - 1);
  localparam logic [FW-1:0] FullCnt = FW'(QUEUE_DEPTH);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SQRT  = 4'd1;
  localparam logic [3:0] S_DIVV  = 4'd2;
  localparam logic [3:0] S_PUSH  = 4'd3;
  localparam logic [3:0] S_POP   = 4'd4;
  localparam logic [3:0] S_STEP  = 4'd5;
  localparam logic [3:0] S_DIVX  = 4'd6;
  localparam logic [3:0] S_DIVY  = 4'd7;
  localparam logic [3:0] S_OUT   = 4'd8;
  localparam logic [3:0] S_LOAD  = 4'd9;

  logic [3:0] state;

  // captured request
  logic [1:0]        func;
  logic [CoordW-1:0] tx, ty;
  logic [VelW-1:0]   vel;

  logic [AW-1:0] head, tail;
  logic [FW-1:0] fill;
  logic [63:0]   queue [QUEUE_DEPTH];
  logic [63:0]   qrd;

  logic signed [CoordW-1:0] last_x, last_y, start_x, start_y, end_x, end_y;
  logic signed [CoordW-1:0] cur_x, cur_y;
  logic [CountW-1:0] steps, done_cnt, count;
  logic active;
  logic moved, dropped;
  logic m_valid;

  // square of differences, one axis per cycle through one multiplier
  logic signed [CoordW:0] diff;
  logic [49:0]            sq_acc;
  logic                   sq_phase;
  logic signed [CoordW:0] lerp_diff;
  logic [CoordW+CountW-1:0] lerp_mag;
  logic                   lerp_neg;

  wpi_cmd_t    cmd;
  logic        u_done;
  logic [49:0] u_res;

  wpi_divsqrt u_unit (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .done   (u_done),
    .result (u_res)
  );

  assign s_tready = (state == S_IDLE) && !m_valid;
  assign m_tvalid = m_valid;
  assign m_tdata  = {cur_y, cur_x};
  assign m_tuser  = {dropped, moved};

  // axis difference for the length, chosen by phase
  always_comb begin
    if (!sq_phase) diff = {tx[CoordW-1], tx} - {last_x[CoordW-1], last_x};
    else           diff = {ty[CoordW-1], ty} - {last_y[CoordW-1], last_y};
  end

  // interpolation magnitude for the axis being divided
  always_comb begin
    if (state == S_STEP) lerp_diff = {end_x[CoordW-1], end_x} - {start_x[CoordW-1], start_x};
    else                 lerp_diff = {end_y[CoordW-1], end_y} - {start_y[CoordW-1], start_y};
    lerp_neg = lerp_diff[CoordW];
    lerp_mag = 40'(lerp_neg ? -lerp_diff : lerp_diff) * done_cnt;
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (state == S_PUSH && fill != FullCnt)
      queue[tail] <= {count, ty, tx};
    qrd <= queue[head];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_valid  <= 1'b0;
      cmd      <= '0;
      head     <= '0;
      tail     <= '0;
      fill     <= '0;
      active   <= 1'b0;
      steps    <= CountW'(1);
      done_cnt <= '0;
      last_x   <= '0;
      last_y   <= '0;
      cur_x    <= '0;
      cur_y    <= '0;
      start_x  <= '0;
      start_y  <= '0;
      end_x    <= '0;
      end_y    <= '0;
      moved    <= 1'b0;
      dropped  <= 1'b0;
      sq_phase <= 1'b0;
    end else begin
      cmd.start <= 1'b0;
      if (m_valid && m_tready) m_valid <= 1'b0;
      unique case (state)
        // take a request word
        S_IDLE: begin
          if (s_tvalid && s_tready) begin
            func     <= s_tuser;
            tx       <= s_tdata[23:0];
            ty       <= s_tdata[47:24];
            vel      <= s_tdata[63:48];
            moved    <= 1'b0;
            dropped  <= 1'b0;
            count    <= CountW'(1);
            sq_phase <= 1'b0;
            sq_acc   <= '0;
            unique case (s_tuser)
              FUNC_MOVE: state <= (s_tdata[63:48] != '0) ? S_SQRT : S_PUSH;
              FUNC_JUMP: state <= S_PUSH;
              FUNC_TICK: state <= S_POP;
              FUNC_RESET: begin
                cur_x    <= s_tdata[23:0];
                cur_y    <= s_tdata[47:24];
                last_x   <= s_tdata[23:0];
                last_y   <= s_tdata[47:24];
                head     <= '0;
                tail     <= '0;
                fill     <= '0;
                active   <= 1'b0;
                steps    <= CountW'(1);
                done_cnt <= '0;
                state    <= S_OUT;
              end
              default: state <= S_OUT;
            endcase
          end
        end
        // sum of squares, then root
        S_SQRT: begin
          if (!sq_phase && !cmd.start) begin
            sq_acc   <= 50'(diff * diff);
            sq_phase <= 1'b1;
          end else if (sq_phase) begin
            cmd.start <= 1'b1;
            cmd.op    <= OP_SQRT;
            cmd.num   <= sq_acc + 50'(diff * diff);
            cmd.den   <= '0;
            sq_phase  <= 1'b0;
            state     <= S_DIVV;
            func      <= FUNC_JUMP;
          end
        end
        // root over velocity
        S_DIVV: begin
          if (u_done) begin
            if (func == FUNC_JUMP) begin
              cmd.start <= 1'b1;
              cmd.op    <= OP_DIV;
              cmd.num   <= u_res;
              cmd.den   <= {16'd0, vel};
              func      <= FUNC_MOVE;
            end else begin
              if (u_res > 50'd65535) count <= 16'hFFFF;
              else if (u_res == '0)  count <= CountW'(1);
              else                   count <= u_res[CountW-1:0];
              state <= S_PUSH;
            end
          end
        end
        // enqueue or drop
        S_PUSH: begin
          if (fill == FullCnt) begin
            dropped <= 1'b1;
          end else begin
            tail   <= (tail == LastIdx) ? '0 : tail + AW'(1);
            fill   <= fill + FW'(1);
            last_x <= tx;
            last_y <= ty;
          end
          state <= S_OUT;
        end
        // pop a segment if idle; the registered queue read is taken up in the load state
        S_POP: begin
          if (!active && fill != '0) begin
            head  <= (head == LastIdx) ? '0 : head + AW'(1);
            fill  <= fill - FW'(1);
            state <= S_LOAD;
          end else if (active) begin
            state <= S_LOAD;
          end else begin
            state <= S_OUT;
          end
        end
        S_LOAD: begin
          if (!active) begin
            start_x  <= cur_x;
            start_y  <= cur_y;
            end_x    <= qrd[23:0];
            end_y    <= qrd[47:24];
            steps    <= (qrd[63:48] == '0) ? CountW'(1) : qrd[63:48];
            done_cnt <= '0;
            active   <= 1'b1;
          end else begin
            moved    <= 1'b1;
            done_cnt <= done_cnt + CountW'(1);
            state    <= S_STEP;
          end
        end
        // advance one step; last step lands on the end point
        S_STEP: begin
          if (done_cnt >= steps) begin
            cur_x    <= end_x;
            cur_y    <= end_y;
            active   <= 1'b0;
            done_cnt <= '0;
            steps    <= CountW'(1);
            state    <= S_OUT;
          end else begin
            cmd.start <= 1'b1;
            cmd.op    <= OP_DIV;
            cmd.num   <= 50'(lerp_mag);
            cmd.den   <= {16'd0, steps};
            func      <= {1'b0, lerp_neg};
            state     <= S_DIVX;
          end
        end
        S_DIVX: begin
          if (u_done) begin
            cur_x <= start_x + (func[0] ? -CoordW'(u_res) : CoordW'(u_res));
            cmd.start <= 1'b1;
            cmd.op    <= OP_DIV;
            cmd.num   <= 50'(lerp_mag);
            cmd.den   <= {16'd0, steps};
            func      <= {1'b0, lerp_neg};
            state     <= S_DIVY;
          end
        end
        S_DIVY: begin
          if (u_done) begin
            cur_y <= start_y + (func[0] ? -CoordW'(u_res) : CoordW'(u_res));
            state <= S_OUT;
          end
        end
        // present the result word
        S_OUT: begin
          m_valid <= 1'b1;
          state   <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // fill never exceeds the queue depth
  a_fill: assert property (@(posedge clk) disable iff (rst) fill <= FullCnt)
    else $error("queue fill above depth");
  // a result word is only raised from the output state
  a_out: assert property (@(posedge clk) disable iff (rst)
    $rose(m_valid) |-> $past(state) == S_OUT)
    else $error("result word raised outside output state");
  // the step count is never zero, whether or not a segment is active
  a_steps: assert property (@(posedge clk) disable iff (rst) steps != '0)
    else $error("zero step count");

endmodule

// ===== tb/waypoint_path_interpolator_tb.sv =====
// ----------------------------------------------------------------------------
// waypoint_path_interpolator_tb: self-checking bench for the path interpolator
// Drives move, jump, tick and reset requests over the input stream, predicts
// each result word from its own copy of the queue and segment state, and
// compares every field of every output word in order.
// ----------------------------------------------------------------------------
module waypoint_path_interpolator_tb
  import wpi_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Depth = DefQueueDepth;
  localparam int LimitCycles = 2000000;

  typedef struct packed {
    logic                     moved;
    logic signed [CoordW-1:0] px;
    logic signed [CoordW-1:0] py;
    logic                     dropped;
  } pos_word_t;

  // path predictor and store of expected result words
  class path_scoreboard;
    logic signed [CoordW-1:0] q_ex[Depth];
    logic signed [CoordW-1:0] q_ey[Depth];
    logic [CountW-1:0]        q_cnt[Depth];
    int fill, head, tail;
    logic signed [CoordW-1:0] last_x, last_y, beg_x, beg_y, end_x, end_y, cx, cy;
    int steps, done_steps;
    bit active;
    pos_word_t pending[$];
    int errors;

    function new();
      fill = 0; head = 0; tail = 0;
      last_x = 0; last_y = 0; beg_x = 0; beg_y = 0; end_x = 0; end_y = 0;
      cx = 0; cy = 0; steps = 1; done_steps = 0; active = 0; errors = 0;
    endfunction

    function longint unsigned int_sqrt(longint unsigned n);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
        if (n >= r + b) begin
          n -= r + b;
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return r;
    endfunction

    function logic signed [CoordW-1:0] lerp(logic signed [CoordW-1:0] b,
        logic signed [CoordW-1:0] e, int s, int c);
      longint d;
      d = longint'(e) - longint'(b);
      return CoordW'(longint'(b) + (d * s) / c);
    endfunction

    // note an accepted request word and queue its expected result
    function void note_request(logic [1:0] fn, logic signed [CoordW-1:0] tx,
        logic signed [CoordW-1:0] ty, logic [VelW-1:0] vel);
      pos_word_t w;
      longint dx, dy;
      longint unsigned q;
      w = '0;
      if (fn == FUNC_MOVE || fn == FUNC_JUMP) begin
        q = 1;
        if (fn == FUNC_MOVE && vel != 0) begin
          dx = longint'(tx) - longint'(last_x);
          dy = longint'(ty) - longint'(last_y);
          q = int_sqrt(longint'(dx * dx) + longint'(dy * dy)) / vel;
          if (q > 65535) q = 65535;
          if (q < 1) q = 1;
        end
        if (fill >= Depth) begin
          w.dropped = 1;
        end else begin
          q_ex[tail] = tx; q_ey[tail] = ty; q_cnt[tail] = CountW'(q);
          tail = (tail + 1) % Depth;
          fill++;
          last_x = tx; last_y = ty;
        end
      end else if (fn == FUNC_TICK) begin
        if (!active && fill != 0) begin
          beg_x = cx; beg_y = cy;
          end_x = q_ex[head]; end_y = q_ey[head];
          steps = (q_cnt[head] == 0) ? 1 : q_cnt[head];
          head = (head + 1) % Depth;
          fill--;
          done_steps = 0;
          active = 1;
        end
        if (active) begin
          w.moved = 1;
          done_steps++;
          if (done_steps >= steps) begin
            cx = end_x; cy = end_y;
            active = 0; done_steps = 0; steps = 1;
          end else begin
            cx = lerp(beg_x, end_x, done_steps, steps);
            cy = lerp(beg_y, end_y, done_steps, steps);
          end
        end
      end else begin
        cx = tx; cy = ty; last_x = tx; last_y = ty;
        fill = 0; head = 0; tail = 0;
        active = 0; steps = 1; done_steps = 0;
      end
      w.px = cx;
      w.py = cy;
      pending.push_back(w);
    endfunction

    // compare one result word with the oldest expectation
    task check_result(logic [47:0] data, logic [1:0] user);
      pos_word_t e;
      if (pending.size() == 0) begin
        report("unexpected result word", 0, 0);
        return;
      end
      e = pending.pop_front();
      if (user[0] !== e.moved) report("moved", user[0], e.moved);
      if (data[23:0] !== e.px) report("pos_x", data[23:0], e.px);
      if (data[47:24] !== e.py) report("pos_y", data[47:24], e.py);
      if (user[1] !== e.dropped) report("dropped", user[1], e.dropped);
    endtask

    task report(string what, longint got, longint want);
      $display("mismatch %s: got %h expected %h", what, got, want);
      errors++;
    endtask
  endclass

  logic        clk = 0;
  logic        rst = 1;
  logic        s_tvalid = 0;
  logic        s_tready;
  logic [63:0] s_tdata = '0;   // target_x, target_y, velocity
  logic [1:0]  s_tuser = '0;   // func
  logic        m_tvalid;
  logic        m_tready = 0;
  logic [47:0] m_tdata;        // pos_x, pos_y
  logic [1:0]  m_tuser;        // moved, dropped

  path_scoreboard sb = new();
  int cycles = 0;
  bit hold_off = 0;
  bit stim_done = 0;
  int burst = 0;

  waypoint_path_interpolator uut (.*);

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  // cycle limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LimitCycles) begin
      $display("waypoint_path_interpolator_tb NOT OK");
      $finish;
    end
  end

  // check result words as they are accepted
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);
  end

  // receiver stall pattern, with one long hold-off
  always @(posedge clk) begin
    if (rst || hold_off) m_tready <= 0;
    else if (cycles % 3000 < 1500) m_tready <= 1;
    else m_tready <= ($urandom_range(0, 3) != 0);
  end

  initial begin
    @(posedge clk);
    wait (cycles > 4000 && !rst);
    hold_off = 1;
    repeat (3000) @(posedge clk);
    hold_off = 0;
  end

  // offer one request word, idling in bursts; returns once it is accepted
  task automatic send_word(logic [1:0] fn, logic [CoordW-1:0] tx, logic [CoordW-1:0] ty,
      logic [VelW-1:0] vel);
    if (burst == 0) begin
      s_tvalid <= 0;
      repeat ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 30)) @(posedge clk);
      burst = $urandom_range(1, 12);
    end
    burst--;
    s_tvalid <= 1;
    s_tuser  <= fn;
    s_tdata  <= {vel, ty, tx};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_request(fn, tx, ty, vel);
  endtask

  function automatic logic [CoordW-1:0] rand_coord(int mode);
    case (mode)
      0: return CoordW'($urandom_range(0, 4000) - 2000);
      1: return CoordW'($urandom);
      2: return $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000;
      default: return CoordW'($urandom_range(0, 200000) - 100000);
    endcase
  endfunction

  initial begin
    int i, k, n;
    logic [1:0] fn;
    logic [VelW-1:0] vel;
    repeat (10) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: extremes, each request kind, zero velocity, full queue
    send_word(FUNC_TICK, 0, 0, 0);
    send_word(FUNC_MOVE, 24'h7FFFFF, 24'h7FFFFF, 16'd1);
    send_word(FUNC_TICK, 0, 0, 0);
    send_word(FUNC_MOVE, 24'h800000, 24'h800000, 16'hFFFF);
    send_word(FUNC_MOVE, 24'h000100, 24'h000000, 16'd0);
    send_word(FUNC_JUMP, 24'h800000, 24'h7FFFFF, 16'hFFFF);
    send_word(FUNC_MOVE, 24'h000500, 24'hFFFB00, 16'h0100);
    for (i = 0; i < 4; i++) send_word(FUNC_TICK, 0, 0, 0);
    send_word(FUNC_RESET, 24'h001234, 24'hFFEDCC, 0);
    for (i = 0; i < 18; i++) send_word(FUNC_JUMP, 24'(i * 256), 24'(-i * 256), 0);
    send_word(FUNC_RESET, 24'h7FFFFF, 24'h800000, 16'hFFFF);

    // random: well-formed paths of moves followed by ticks, plus noise
    n = 0;
    while (n < 1500) begin
      k = $urandom_range(1, 6);
      for (i = 0; i < k; i++) begin
        vel = ($urandom_range(0, 9) == 0) ? VelW'($urandom) : VelW'($urandom_range(0, 1200));
        fn = ($urandom_range(0, 4) == 0) ? FUNC_JUMP : FUNC_MOVE;
        send_word(fn, rand_coord($urandom_range(0, 3)), rand_coord($urandom_range(0, 3)), vel);
        n++;
      end
      k = $urandom_range(0, 40);
      for (i = 0; i < k; i++) begin
        send_word(FUNC_TICK, CoordW'($urandom), CoordW'($urandom), VelW'($urandom));
        n++;
      end
      if ($urandom_range(0, 30) == 0) begin
        send_word(FUNC_RESET, rand_coord($urandom_range(0, 3)),
                  rand_coord($urandom_range(0, 3)), VelW'($urandom));
        n++;
      end
    end
    s_tvalid <= 0;
    stim_done = 1;
  end

  // end of run
  initial begin
    wait (stim_done);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (sb.errors == 0) begin
      $display("waypoint_path_interpolator_tb OK");
    end else begin
      $display("waypoint_path_interpolator_tb NOT OK");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/wpi_pkg.sv
hdl/wpi_divsqrt.sv
hdl/waypoint_path_interpolator.sv
tb/waypoint_path_interpolator_tb.sv
